>>> design/nct_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_pkg
// Shared widths, register map and controller/datapath command types for the
// nearest centroid tracker.
// ----------------------------------------------------------------------------
package nct_pkg;

    // default configuration
    localparam int MAX_OBJECTS_DEF = 64;
    localparam int COORD_BITS_DEF  = 16;

    // item field widths
    localparam int POS_W     = 16;
    localparam int OUT_IDX_W = 6;
    localparam int DIST_W    = 34;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int RADIUS_W   = 16;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd100;

    // register index (paddr[2]); index 1 lies beyond the map
    localparam logic REG_MATCH_RADIUS = 1'b0;

    typedef struct packed {
        logic load;         // capture item, restart scan
        logic scan;         // issue next committed-table read
        logic commit;       // decide, update pending table, load result
        logic copy;         // copy pending entries to committed table
        logic copy_finish;  // copy complete, commit count
    } nct_cmd_t;

    typedef struct packed {
        logic scan_done;
        logic copy_done;
        logic frame_end;
    } nct_status_t;

endpackage

>>> design/nct_cand_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_cand_if
// Candidate centroid channel: valid/ready with one centroid per item.
// ----------------------------------------------------------------------------
interface nct_cand_if;
    import nct_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic                    frame_end;

    modport source (output valid, pos_x, pos_y, pos_z, frame_end, input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, frame_end, output ready);

endinterface

>>> design/nct_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_res_if
// Association result channel: valid/ready with one result per item.
// ----------------------------------------------------------------------------
interface nct_res_if;
    import nct_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 matched;
    logic [OUT_IDX_W-1:0] entry_index;
    logic [DIST_W-1:0]    nearest_sq_distance;
    logic                 table_full;

    modport source (output valid, matched, entry_index, nearest_sq_distance, table_full,
                    input ready);
    modport sink   (input valid, matched, entry_index, nearest_sq_distance, table_full,
                    output ready);

endinterface

>>> design/nearest_centroid_tracker_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_centroid_tracker_core
// Nearest-neighbour centroid association with a distance gate.
// ----------------------------------------------------------------------------
// Usage:
//   cand carries one new centroid per item (pos_x/y/z, frame_end); res returns
//   exactly one item per candidate, in order (matched, entry_index,
//   nearest_sq_distance, table_full). Both are valid/ready channels.
//   match_radius sits at APB byte address 0; write it only while idle.
// Operation:
//   A candidate is compared against the committed table, one entry per cycle
//   through a four-stage read/difference/square/minimum pipe. Once the scan
//   drains, the decision loads the result; without frame_end the next item
//   is accepted the cycle after the result is loaded. An item with frame_end
//   adds a copy of the pending table into the committed table, one entry per
//   cycle, before the next accept.
// Reset:
//   Both tables empty, match_radius = 100. No clearing pass: entries are only
//   read below their fill counts.
// Stall:
//   A finished result waits in the output register; a further result waits
//   in the decision step until the receiver takes the first, no item is lost.
// ----------------------------------------------------------------------------
module nearest_centroid_tracker_core #(
    parameter int MAX_OBJECTS = nct_pkg::MAX_OBJECTS_DEF,
    parameter int COORD_BITS  = nct_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    nct_cand_if.sink                          cand,
    nct_res_if.source                         res,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nct_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [nct_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [nct_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import nct_pkg::*;

    logic [RADIUS_W-1:0] match_radius_reg, match_radius_next;
    logic                cfg_wr;
    logic                reg_sel;
    nct_cmd_t            cmd;
    nct_status_t         status;

    // ------------------------------------------------------------------
    // Configuration: one register, word index in paddr[2]
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_MATCH_RADIUS);
    assign cfg_wr  = psel && penable && pwrite && pready && reg_sel;

    always_comb
    begin
        match_radius_next = match_radius_reg;
        if (cfg_wr)
        begin
            match_radius_next = pwdata[RADIUS_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_radius_reg <= RADIUS_RESET;
        end
        else
        begin
            match_radius_reg <= match_radius_next;
        end
    end

    // reads of the unmapped word return zero; byte offset is ignored
    assign prdata = reg_sel ? APB_DATA_W'(match_radius_reg) : '0;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    nct_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cand_valid (cand.valid),
        .cand_ready (cand.ready),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // ------------------------------------------------------------------
    // Tables, distance pipe and decision
    // ------------------------------------------------------------------
    nct_datapath #(
        .MAX_OBJECTS (MAX_OBJECTS),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .status              (status),
        .pos_x               (cand.pos_x),
        .pos_y               (cand.pos_y),
        .pos_z               (cand.pos_z),
        .frame_end           (cand.frame_end),
        .match_radius        (match_radius_reg),
        .matched             (res.matched),
        .entry_index         (res.entry_index),
        .nearest_sq_distance (res.nearest_sq_distance),
        .table_full          (res.table_full)
    );

endmodule

>>> design/nct_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_datapath
// Committed/pending centroid tables, distance pipeline, nearest search,
// association decision and commit copy.
// ----------------------------------------------------------------------------
module nct_datapath #(
    parameter int MAX_OBJECTS = nct_pkg::MAX_OBJECTS_DEF,
    parameter int COORD_BITS  = nct_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  nct_pkg::nct_cmd_t                   cmd,
    output nct_pkg::nct_status_t                status,
    input  logic signed [nct_pkg::POS_W-1:0]    pos_x,
    input  logic signed [nct_pkg::POS_W-1:0]    pos_y,
    input  logic signed [nct_pkg::POS_W-1:0]    pos_z,
    input  logic                                frame_end,
    input  logic [nct_pkg::RADIUS_W-1:0]        match_radius,
    output logic                                matched,
    output logic [nct_pkg::OUT_IDX_W-1:0]       entry_index,
    output logic [nct_pkg::DIST_W-1:0]          nearest_sq_distance,
    output logic                                table_full
);
    import nct_pkg::*;

    localparam int IW    = $clog2(MAX_OBJECTS);
    localparam int CNT_W = $clog2(MAX_OBJECTS + 1);
    localparam int CW    = COORD_BITS;
    localparam int SQ_W  = 2 * CW;
    localparam int DW    = 2 * CW + 2;
    localparam int RSQ_W = 2 * RADIUS_W;
    localparam int CMP_W = (DW > RSQ_W) ? DW : RSQ_W;
    localparam int ENT_W = 3 * CW;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_OBJECTS);

    function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a,
                                               input logic [CW-1:0] b);
        logic signed [CW:0] d;
        d = $signed({a[CW-1], a}) - $signed({b[CW-1], b});
        abs_diff = d[CW] ? CW'(-d) : CW'(d);
    endfunction

    // query and gate
    logic [CW-1:0]    q_x_reg, q_y_reg, q_z_reg;
    logic             frame_end_reg;
    logic [RSQ_W-1:0] rad_sq_reg;

    // table state
    logic [ENT_W-1:0] comm_mem [MAX_OBJECTS];
    logic [ENT_W-1:0] pend_mem [MAX_OBJECTS];
    logic [CNT_W-1:0] committed_count_reg, committed_count_next;
    logic [CNT_W-1:0] pending_count_reg, pending_count_next;

    // scan pipeline
    logic [CNT_W-1:0] scan_cnt_reg;
    logic [ENT_W-1:0] comm_rd_reg;
    logic             s1_vld_reg, s2_vld_reg, s3_vld_reg;
    logic [IW-1:0]    s1_idx_reg, s2_idx_reg, s3_idx_reg;
    logic [CW-1:0]    ad_x_reg, ad_y_reg, ad_z_reg;
    logic [SQ_W-1:0]  sq_x_reg, sq_y_reg, sq_z_reg;
    logic [DW-1:0]    best_reg;
    logic [IW-1:0]    best_idx_reg;
    logic             best_vld_reg;

    // commit copy
    logic [CNT_W-1:0] copy_cnt_reg;
    logic [ENT_W-1:0] pend_rd_reg;
    logic             copy_wr_vld_reg;
    logic [IW-1:0]    copy_wr_idx_reg;

    logic             scan_issue, copy_issue;
    logic [DW-1:0]    sum_sq;
    logic             dist_better;
    logic             have_entries, hit, room;
    logic [IW-1:0]    wr_idx;

    assign scan_issue   = cmd.scan && (scan_cnt_reg != committed_count_reg);
    assign copy_issue   = cmd.copy && (copy_cnt_reg != pending_count_reg);
    assign sum_sq       = DW'(sq_x_reg) + DW'(sq_y_reg) + DW'(sq_z_reg);
    assign dist_better  = !best_vld_reg || (sum_sq < best_reg);
    assign have_entries = (committed_count_reg != '0);
    assign hit          = have_entries && (CMP_W'(best_reg) < CMP_W'(rad_sq_reg));
    assign room         = (pending_count_reg < MAX_CNT);
    assign wr_idx       = hit ? best_idx_reg : pending_count_reg[IW-1:0];

    assign status.scan_done = (scan_cnt_reg == committed_count_reg)
                              && !s1_vld_reg && !s2_vld_reg && !s3_vld_reg;
    assign status.copy_done = (copy_cnt_reg == pending_count_reg) && !copy_wr_vld_reg;
    assign status.frame_end = frame_end_reg;

    always_comb
    begin
        pending_count_next   = pending_count_reg;
        committed_count_next = committed_count_reg;
        if (cmd.commit && !hit && room)
        begin
            pending_count_next = pending_count_reg + CNT_W'(1);
        end
        if (cmd.copy_finish)
        begin
            committed_count_next = pending_count_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            committed_count_reg <= '0;
            pending_count_reg   <= '0;
            scan_cnt_reg        <= '0;
            s1_vld_reg          <= 1'b0;
            s2_vld_reg          <= 1'b0;
            s3_vld_reg          <= 1'b0;
            best_vld_reg        <= 1'b0;
            copy_cnt_reg        <= '0;
            copy_wr_vld_reg     <= 1'b0;
        end
        else
        begin
            committed_count_reg <= committed_count_next;
            pending_count_reg   <= pending_count_next;
            s1_vld_reg          <= scan_issue;
            s2_vld_reg          <= s1_vld_reg;
            s3_vld_reg          <= s2_vld_reg;
            copy_wr_vld_reg     <= copy_issue;
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
                best_vld_reg <= 1'b0;
                copy_cnt_reg <= '0;
            end
            else
            begin
                if (scan_issue)
                begin
                    scan_cnt_reg <= scan_cnt_reg + CNT_W'(1);
                end
                if (s3_vld_reg)
                begin
                    best_vld_reg <= 1'b1;
                end
                if (copy_issue)
                begin
                    copy_cnt_reg <= copy_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        rad_sq_reg <= RSQ_W'(match_radius) * RSQ_W'(match_radius);
        if (cmd.load)
        begin
            q_x_reg       <= CW'($unsigned(pos_x));
            q_y_reg       <= CW'($unsigned(pos_y));
            q_z_reg       <= CW'($unsigned(pos_z));
            frame_end_reg <= frame_end;
        end

        // stage 1: committed table read
        s1_idx_reg <= scan_cnt_reg[IW-1:0];
        // stage 2: absolute differences
        ad_x_reg   <= abs_diff(q_x_reg, comm_rd_reg[CW-1:0]);
        ad_y_reg   <= abs_diff(q_y_reg, comm_rd_reg[2*CW-1:CW]);
        ad_z_reg   <= abs_diff(q_z_reg, comm_rd_reg[3*CW-1:2*CW]);
        s2_idx_reg <= s1_idx_reg;
        // stage 3: squares
        sq_x_reg   <= SQ_W'(ad_x_reg) * SQ_W'(ad_x_reg);
        sq_y_reg   <= SQ_W'(ad_y_reg) * SQ_W'(ad_y_reg);
        sq_z_reg   <= SQ_W'(ad_z_reg) * SQ_W'(ad_z_reg);
        s3_idx_reg <= s2_idx_reg;

        // stage 4: sum and running minimum, lowest index kept on ties
        if (cmd.load)
        begin
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else if (s3_vld_reg && dist_better)
        begin
            best_reg     <= sum_sq;
            best_idx_reg <= s3_idx_reg;
        end

        if (cmd.commit)
        begin
            matched             <= hit;
            entry_index         <= (hit || room) ? OUT_IDX_W'(wr_idx) : '0;
            nearest_sq_distance <= DIST_W'(best_reg);
            table_full          <= !hit && !room;
        end

        copy_wr_idx_reg <= copy_cnt_reg[IW-1:0];
    end

    // committed table: read during scan, written during copy
    always_ff @(posedge clk)
    begin
        if (scan_issue)
        begin
            comm_rd_reg <= comm_mem[scan_cnt_reg[IW-1:0]];
        end
        if (copy_wr_vld_reg)
        begin
            comm_mem[copy_wr_idx_reg] <= pend_rd_reg;
        end
    end

    // pending table: written on decision, read during copy
    always_ff @(posedge clk)
    begin
        if (cmd.commit && (hit || room))
        begin
            pend_mem[wr_idx] <= {q_z_reg, q_y_reg, q_x_reg};
        end
        if (copy_issue)
        begin
            pend_rd_reg <= pend_mem[copy_cnt_reg[IW-1:0]];
        end
    end

    // committed count never exceeds pending count
    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        committed_count_reg <= pending_count_reg)
        else $error("committed count exceeds pending count");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        pending_count_reg <= MAX_CNT)
        else $error("pending count beyond table size");

    a_copy_range: assert property (@(posedge clk) disable iff (!rst_n)
        copy_wr_vld_reg |-> (CNT_W'(copy_wr_idx_reg) < pending_count_reg))
        else $error("copy writes an unfilled slot");

    a_decide_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!s1_vld_reg && !s2_vld_reg && !s3_vld_reg
                        && (scan_cnt_reg == committed_count_reg)))
        else $error("decision taken before scan drained");

endmodule

>>> design/nct_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nct_ctrl
// Sequencer for one item: accept, scan, decide, optional commit copy.
// Owns the handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module nct_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cand_valid,
    output logic                 cand_ready,
    output logic                 res_valid,
    input  logic                 res_ready,
    input  nct_pkg::nct_status_t status,
    output nct_pkg::nct_cmd_t    cmd
);
    import nct_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_RESULT = 4'b0100,
        ST_COPY   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   res_valid_reg, res_valid_next;
    logic   out_free;

    assign out_free   = !res_valid_reg || res_ready;
    assign cand_ready = (state_reg == ST_IDLE);
    assign res_valid  = res_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (cand_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = status.frame_end ? ST_COPY : ST_IDLE;
                end
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (status.copy_done)
                begin
                    cmd.copy_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (cmd.commit)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

endmodule
